@@ rtl/avt_pkg.sv @@
// Shared types and constants of the averaged ADC temperature block.
package avt_pkg;

    localparam int SAMPLE_W = 12;
    localparam int TEMP_W   = 17;

    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 12'hFFF;

    // Average = floor(sum * ceil(2^AVG_SHIFT / depth) / 2^AVG_SHIFT), exact for depth <= 256
    localparam int AVG_SHIFT = 28;
    localparam int RECIP_W   = 28;

    // Sensor law with the common factor 32 taken out:
    //   centi = 2500 + round((OFFSET_N - SLOPE_N * avg) / 5504), 5504 = 43 * 128
    localparam int NUM_W   = 29;
    localparam int MAG_W   = 28;
    localparam int SLOPE_W = 17;
    localparam logic signed [NUM_W-1:0] OFFSET_N  = 29'sd183040000;
    localparam logic [SLOPE_W-1:0]      SLOPE_N   = 17'd103125;
    localparam logic [MAG_W-1:0]        HALF_DEN  = 28'd2752;
    localparam int                      DEN_SHIFT = 7;

    // Divide by 43 as multiply by ceil(2^27 / 43), exact for dividends below 2^21
    localparam int                 DIV_W      = MAG_W - DEN_SHIFT;
    localparam int                 R43_W      = 22;
    localparam int                 R43_SHIFT  = 27;
    localparam logic [R43_W-1:0]   RECIP_43   = 22'd3121343;
    localparam int                 QUOT_W     = 16;

    localparam logic signed [TEMP_W-1:0] BASE_CENTI = 17'sd2500;

    typedef struct packed {
        logic valid;
        logic warm;
    } t_stage_ctl;

endpackage

@@ rtl/avt_sample_if.sv @@
// Sample channel: valid/ready handshake carrying one ADC conversion.
interface avt_sample_if import avt_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

@@ rtl/avt_temp_if.sv @@
// Result channel: valid/ready handshake carrying one temperature reading.
interface avt_temp_if import avt_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [TEMP_W-1:0] temperature_centi;
    logic                     warmed_up;

    modport source (output valid, output temperature_centi, output warmed_up, input ready);
    modport sink   (input valid, input temperature_centi, input warmed_up, output ready);
endinterface

@@ rtl/avt_cell.sv @@
// One window cell: holds a sample and hands it to its neighbor on each shift.
module avt_cell import avt_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_shift,
    input  logic [SAMPLE_W-1:0] i_d,
    output logic [SAMPLE_W-1:0] o_q
);

    logic [SAMPLE_W-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= SAMPLE_MAX;
        end else if (i_shift) begin
            r_q <= i_d;
        end
    end

    assign o_q = r_q;

endmodule

@@ rtl/avt_window.sv @@
// Sample window: chain of cells, running sum and warm-up tracking.
module avt_window import avt_pkg::*; #(
    parameter int WINDOW_DEPTH = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_valid,
    input  logic [SAMPLE_W-1:0]                      i_sample,
    output logic                                     o_ready,
    input  logic                                     i_free_next,
    output t_stage_ctl                               o_ctl,
    output logic [SAMPLE_W+$clog2(WINDOW_DEPTH)-1:0] o_sum
);

    localparam int SUM_W = SAMPLE_W + $clog2(WINDOW_DEPTH);
    localparam int CNT_W = $clog2(WINDOW_DEPTH);
    localparam logic [SUM_W-1:0] SUM_RESET = SUM_W'(4095 * WINDOW_DEPTH);
    localparam logic [CNT_W-1:0] CNT_LAST  = CNT_W'(WINDOW_DEPTH - 1);

    logic [SAMPLE_W-1:0] w_tap [WINDOW_DEPTH+1];
    logic                w_free;
    logic                w_accept;
    logic [SUM_W-1:0]    n_sum;
    logic [CNT_W-1:0]    n_cnt;
    logic [SUM_W-1:0]    r_sum;
    logic [CNT_W-1:0]    r_cnt;
    logic                r_full;
    logic                r_valid;
    logic                r_warm;

    assign w_tap[0] = i_sample;

    for (genvar k = 0; k < WINDOW_DEPTH; k++) begin : g_cell
        avt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (w_accept),
            .i_d     (w_tap[k]),
            .o_q     (w_tap[k+1])
        );
    end

    assign w_free   = !r_valid || i_free_next;
    assign w_accept = i_valid && w_free;
    assign o_ready  = w_free;

    // Oldest sample falls out of the last cell
    assign n_sum = r_sum - SUM_W'(w_tap[WINDOW_DEPTH]) + SUM_W'(i_sample);
    assign n_cnt = r_cnt + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= SUM_RESET;
            r_cnt   <= '0;
            r_full  <= 1'b0;
            r_valid <= 1'b0;
            r_warm  <= 1'b0;
        end else begin
            if (w_accept) begin
                r_sum <= n_sum;
                if (!r_full) begin
                    r_cnt <= n_cnt;
                    if (n_cnt == CNT_LAST) begin
                        r_full <= 1'b1;
                    end
                end
            end
            if (w_free) begin
                r_valid <= i_valid;
                r_warm  <= r_full;
            end
        end
    end

    // The accumulator itself is the stage payload: it only moves with a transfer
    assign o_sum       = r_sum;
    assign o_ctl.valid = r_valid;
    assign o_ctl.warm  = r_warm;

endmodule

@@ rtl/avt_convert.sv @@
// Conversion pipeline: average, sensor law, rounding and output register.
module avt_convert import avt_pkg::*; #(
    parameter int WINDOW_DEPTH = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  t_stage_ctl                               i_ctl,
    input  logic [SAMPLE_W+$clog2(WINDOW_DEPTH)-1:0] i_sum,
    output logic                                     o_free,
    output logic                                     o_valid,
    input  logic                                     i_ready,
    output logic signed [TEMP_W-1:0]                 o_temperature_centi,
    output logic                                     o_warmed_up
);

    localparam int SUM_W  = SAMPLE_W + $clog2(WINDOW_DEPTH);
    localparam int PROD_W = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << AVG_SHIFT) + 64'(WINDOW_DEPTH) - 64'd1) / 64'(WINDOW_DEPTH));

    logic [PROD_W-1:0]              w_avg_prod;
    logic [NUM_W-1:0]               w_slope;
    logic signed [NUM_W-1:0]        w_num;
    logic [MAG_W-1:0]               w_mag;
    logic [MAG_W-1:0]               w_biased;
    logic [DIV_W+R43_W-1:0]         w_q_prod;
    logic signed [TEMP_W-1:0]       w_q_s;
    logic signed [TEMP_W-1:0]       w_temp;
    logic                           w_free2;
    logic                           w_free3;
    logic                           w_free4;
    logic                           w_free5;

    t_stage_ctl                     r_ctl2;
    t_stage_ctl                     r_ctl3;
    t_stage_ctl                     r_ctl4;
    t_stage_ctl                     r_ctl5;
    logic [SAMPLE_W-1:0]            r_avg;
    logic signed [NUM_W-1:0]        r_num;
    logic [QUOT_W-1:0]              r_q;
    logic                           r_neg;
    logic signed [TEMP_W-1:0]       r_temp;

    assign w_free5 = !r_ctl5.valid || i_ready;
    assign w_free4 = !r_ctl4.valid || w_free5;
    assign w_free3 = !r_ctl3.valid || w_free4;
    assign w_free2 = !r_ctl2.valid || w_free3;
    assign o_free  = w_free2;

    assign w_avg_prod = PROD_W'(i_sum) * PROD_W'(RECIP);
    assign w_slope    = NUM_W'(SLOPE_N) * NUM_W'(r_avg);
    assign w_num      = OFFSET_N - $signed(w_slope);
    assign w_mag      = r_num[NUM_W-1] ? MAG_W'(-r_num) : MAG_W'(r_num);
    assign w_biased   = w_mag + HALF_DEN;
    assign w_q_prod   = (DIV_W+R43_W)'(w_biased[MAG_W-1:DEN_SHIFT]) * (DIV_W+R43_W)'(RECIP_43);
    assign w_q_s      = $signed({1'b0, r_q});
    assign w_temp     = r_neg ? (BASE_CENTI - w_q_s) : (BASE_CENTI + w_q_s);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl2 <= '0;
            r_ctl3 <= '0;
            r_ctl4 <= '0;
            r_ctl5 <= '0;
        end else begin
            if (w_free2) begin
                r_ctl2 <= i_ctl;
            end
            if (w_free3) begin
                r_ctl3 <= r_ctl2;
            end
            if (w_free4) begin
                r_ctl4 <= r_ctl3;
            end
            if (w_free5) begin
                r_ctl5 <= r_ctl4;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_free2) begin
            r_avg <= w_avg_prod[AVG_SHIFT+SAMPLE_W-1:AVG_SHIFT];
        end
        if (w_free3) begin
            r_num <= w_num;
        end
        if (w_free4) begin
            r_q   <= w_q_prod[R43_SHIFT+QUOT_W-1:R43_SHIFT];
            r_neg <= r_num[NUM_W-1];
        end
        if (w_free5) begin
            // Hold the fixed warm-up reading until the window has filled
            r_temp <= r_ctl4.warm ? w_temp : BASE_CENTI;
        end
    end

    assign o_valid             = r_ctl5.valid;
    assign o_temperature_centi = r_temp;
    assign o_warmed_up         = r_ctl5.warm;

endmodule

@@ rtl/averaged_adc_temperature.sv @@
// Path: a transferred sample updates the window sum register, then passes the average,
// numerator, quotient and output registers before its reading can transfer.
// Throughput: one sample per cycle while readings are taken; a stage advances when the
// next one is free, so bubbles close up and input is taken while the output waits.
// The window sum is updated at the input transfer; average, scaling and rounding
// follow in four registered stages, each with at most one multiplier.
// Reset: window cells read 4095, sum 4095 * depth, warm-up restarts, pipeline empties.
module averaged_adc_temperature import avt_pkg::*; #(
    parameter int WINDOW_DEPTH = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    avt_sample_if.sink   i_sample,
    avt_temp_if.source   o_temp
);

    localparam int SUM_W = SAMPLE_W + $clog2(WINDOW_DEPTH);

    t_stage_ctl       w_ctl;
    logic [SUM_W-1:0] w_sum;
    logic             w_free;

    avt_window #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_window (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_sample.valid),
        .i_sample    (i_sample.sample),
        .o_ready     (i_sample.ready),
        .i_free_next (w_free),
        .o_ctl       (w_ctl),
        .o_sum       (w_sum)
    );

    avt_convert #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_convert (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_ctl               (w_ctl),
        .i_sum               (w_sum),
        .o_free              (w_free),
        .o_valid             (o_temp.valid),
        .i_ready             (o_temp.ready),
        .o_temperature_centi (o_temp.temperature_centi),
        .o_warmed_up         (o_temp.warmed_up)
    );

    a_warmup_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_temp.valid && !o_temp.warmed_up |-> o_temp.temperature_centi == BASE_CENTI)
        else $error("warm-up reading differs from base value");

    a_empty_takes_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_temp.valid |-> i_sample.ready)
        else $error("input stalled with empty output register");

    a_warm_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_temp.valid && o_temp.ready && o_temp.warmed_up
            |=> !(o_temp.valid && !o_temp.warmed_up))
        else $error("warm-up reading after a computed reading");

endmodule
